[rtl/tlrq_pkg.sv]
`default_nettype none
package tlrq_pkg;

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_REM   = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_DONE = 2'd2
    } fsm_t;

    localparam logic [0:0] REG_MID_FLOOR = 1'b0;
    localparam logic [0:0] REG_TOP_FLOOR = 1'b1;
    localparam logic [7:0] MID_FLOOR_RST = 8'd50;
    localparam logic [7:0] TOP_FLOOR_RST = 8'd100;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [7:0]  task_priority;
        logic [15:0] burst_estimate;
        logic [15:0] elapsed_ticks;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_id;
        logic [1:0]  chosen_level;
        logic        preempt;
        logic        top_nonempty;
        logic        mid_nonempty;
    } result_t;

    // one table entry as carried along the scan
    typedef struct packed {
        logic        used;
        logic [15:0] id;
        logic [1:0]  level;
        logic [16:0] key;
        logic [31:0] arrival;
    } entry_t;

    // true when a is served before b (same level, both used)
    function automatic logic entry_ahead(entry_t a, entry_t b);
        logic        r;
        logic [31:0] d;
        begin
            d = a.arrival - b.arrival;
            r = d[31];
            if (a.level != 2'd3 && a.id != b.id)
                r = a.id < b.id;
            if (a.level == 2'd2 && a.key != b.key)
                r = $signed(a.key) > $signed(b.key);
            if (a.level == 2'd1 && a.key != b.key)
                r = $signed(a.key) < $signed(b.key);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/tlrq_cell.sv]
`default_nettype none
// one slot of the circular table; in rotate mode passes its entry to the next cell
module tlrq_cell
    import tlrq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire logic   load,
    input  wire entry_t load_val,
    input  wire entry_t prev_val,
    output entry_t      val
);
    logic   used_reg;
    entry_t data_reg;
    entry_t in_val;

    always_comb
    begin
        in_val = load ? load_val : prev_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg <= in_val.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= in_val;
        end
    end

    always_comb
    begin
        val      = data_reg;
        val.used = used_reg;
    end
endmodule
`default_nettype wire

[rtl/three_level_ready_queue_scheduler.sv]
`default_nettype none
// channel  | direction | handshake            | payload
// command  | in        | start & !busy        | cmd (cmd_t)
// result   | out       | done strobe, 1 cycle | result (result_t)
// config   | in        | cfg_valid & cfg_ready| cfg_index, cfg_data
// Each command rotates the cell ring twice, search then update, and then raises done;
// the next command is accepted once the block has returned to idle after done.
// The ring of cells shifts one place per cycle past a single compare unit.
// Reset clears all used flags and the arrival counter and restores the floors.
// The receiver cannot stall; done is high for exactly one cycle.
module three_level_ready_queue_scheduler
    import tlrq_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic    cfg_index,
    input  wire logic [7:0] cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    fsm_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_t cmd_reg;
    logic [7:0] mid_floor_reg, top_floor_reg;
    logic [31:0] arr_reg;
    // pass results
    logic found_reg, found_next;
    entry_t best_reg, best_next;
    logic [AW-1:0] best_pos_reg, best_pos_next;
    logic free_reg, free_next;
    logic [AW-1:0] free_pos_reg, free_pos_next;
    logic top_ne_reg, top_ne_next, mid_ne_reg, mid_ne_next;
    logic [1:0] lvl_reg, lvl_next;

    entry_t cell_val [TABLE_DEPTH];
    entry_t head;
    logic   shift;
    logic   load;
    entry_t load_val;
    logic [1:0] cmd_lvl;
    logic [16:0] remain;
    logic cand;
    logic [1:0] hl;

    assign head   = cell_val[TABLE_DEPTH-1];
    assign remain = {1'b0, cmd_reg.burst_estimate} - {1'b0, cmd_reg.elapsed_ticks};
    assign cmd_lvl = (cmd_reg.task_priority >= top_floor_reg) ? 2'd1 :
                     (cmd_reg.task_priority >= mid_floor_reg) ? 2'd2 : 2'd3;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            tlrq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .load     (g == 0 ? load : 1'b0),
                .load_val (load_val),
                .prev_val (g == 0 ? head : cell_val[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
                .val      (cell_val[g])
            );
        end
    endgenerate

    // ring position of head at scan step k is k; after a full rotation, all back in place
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (start) state_next = FSM_SCAN;
            FSM_SCAN: if (cnt_reg == CW'(2 * TABLE_DEPTH - 1)) state_next = FSM_DONE;
            FSM_DONE: state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // pass 1 (cnt < DEPTH): search; pass 2: apply the change when head is at the target slot
    logic pass2;
    logic [AW-1:0] pos;
    assign pass2 = cnt_reg >= CW'(TABLE_DEPTH);
    assign pos   = pass2 ? AW'(cnt_reg - CW'(TABLE_DEPTH)) : AW'(cnt_reg);

    always_comb
    begin
        hl = 2'd0;
        case (cmd_reg.action)
            ACT_DEQ:   hl = 2'd0;
            ACT_REM:   hl = cmd_lvl;
            ACT_QUERY: hl = 2'd1;
            default:   hl = 2'd0;
        endcase
        cand = head.used && (cmd_reg.action == ACT_DEQ ? 1'b1 :
               (cmd_reg.action == ACT_ENQ ? 1'b0 :
               (head.level == hl && (cmd_reg.action != ACT_REM || head.id == cmd_reg.task_id))));
    end

    logic [1:0] pri_new, pri_old;
    always_comb
    begin
        pri_new = head.level;
        pri_old = lvl_reg;
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_pos_next = best_pos_reg;
        free_next     = free_reg;
        free_pos_next = free_pos_reg;
        top_ne_next   = top_ne_reg;
        mid_ne_next   = mid_ne_reg;
        lvl_next      = lvl_reg;
        shift         = 1'b0;
        load          = 1'b0;
        load_val      = head;
        if (state_reg == FSM_IDLE && start)
        begin
            cnt_next = '0;
            found_next = 1'b0;
            free_next = 1'b0;
            top_ne_next = 1'b0;
            mid_ne_next = 1'b0;
        end
        else if (state_reg == FSM_SCAN)
        begin
            shift = 1'b1;
            cnt_next = CW'(cnt_reg + 1'b1);
            if (!pass2)
            begin
                if (!head.used && !free_reg)
                begin
                    free_next = 1'b1;
                    free_pos_next = pos;
                end
                if (cand)
                begin
                    if (!found_reg || pri_new < pri_old ||
                        (pri_new == pri_old && entry_ahead(head, best_reg)))
                    begin
                        found_next = 1'b1;
                        best_next = head;
                        best_pos_next = pos;
                        lvl_next = pri_new;
                    end
                end
            end
            else
            begin
                load = 1'b1;
                load_val = head;
                if (cmd_reg.action == ACT_ENQ && free_reg && pos == free_pos_reg)
                begin
                    load_val.used = 1'b1;
                    load_val.id = cmd_reg.task_id;
                    load_val.level = cmd_lvl;
                    load_val.key = (cmd_lvl == 2'd1) ? remain : {9'd0, cmd_reg.task_priority};
                    load_val.arrival = arr_reg;
                end
                else if (cmd_reg.action inside {ACT_DEQ, ACT_REM} &&
                         found_reg && pos == best_pos_reg)
                begin
                    load_val.used = 1'b0;
                end
                if (load_val.used && load_val.level == 2'd1) top_ne_next = 1'b1;
                if (load_val.used && load_val.level == 2'd2) mid_ne_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy = (state_reg != FSM_IDLE);
        done = (state_reg == FSM_DONE);
        cfg_ready = (state_reg == FSM_IDLE) && !start;
        result = '0;
        result.top_nonempty = top_ne_reg;
        result.mid_nonempty = mid_ne_reg;
        case (cmd_reg.action)
            ACT_ENQ: result.status = free_reg ? ST_OK : ST_FULL;
            ACT_DEQ:
            begin
                result.status = found_reg ? ST_OK : ST_EMPTY;
                if (found_reg)
                begin
                    result.chosen_id = best_reg.id;
                    result.chosen_level = best_reg.level;
                end
            end
            ACT_REM: result.status = found_reg ? ST_OK : ST_NOTFOUND;
            ACT_QUERY:
            begin
                result.status = ST_OK;
                result.preempt = found_reg && ($signed(best_reg.key) < $signed(remain) ||
                    (best_reg.key == remain && best_reg.id < cmd_reg.task_id));
            end
            default: result.status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            mid_floor_reg <= MID_FLOOR_RST;
            top_floor_reg <= TOP_FLOOR_RST;
            arr_reg       <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            top_ne_reg    <= 1'b0;
            mid_ne_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            found_reg  <= found_next;
            free_reg   <= free_next;
            top_ne_reg <= top_ne_next;
            mid_ne_reg <= mid_ne_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MID_FLOOR) mid_floor_reg <= cfg_data;
                else top_floor_reg <= cfg_data;
            end
            if (state_reg == FSM_DONE && cmd_reg.action == ACT_ENQ && free_reg)
                arr_reg <= arr_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && start) cmd_reg <= cmd;
        best_reg     <= best_next;
        best_pos_reg <= best_pos_next;
        free_pos_reg <= free_pos_next;
        lvl_reg      <= lvl_next;
    end

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while idle");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n) busy |-> !cfg_ready)
        else $error("cfg while busy");
endmodule
`default_nettype wire
